// File: design/ptd_pkg.sv
// ptd_pkg: shared types and constants for the PID trapezoid dead-band core.
// No dependencies.
package ptd_pkg;

	localparam int unsigned REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PROP   = 3'd0,
		REG_INTEG  = 3'd1,
		REG_DERIV  = 3'd2,
		REG_TARGET = 3'd3,
		REG_DBAND  = 3'd4,
		REG_MODE   = 3'd5
	} reg_idx_t;

	localparam int unsigned TERM_SHIFT = 60;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ISUM_MUL,
		ST_ISUM_DIV,
		ST_DNUM_MUL,
		ST_DNUM_DIV,
		ST_P_MUL,
		ST_I_MUL,
		ST_D_MUL,
		ST_SUM,
		ST_OUT
	} state_t;

	// request to the serial multiplier
	typedef struct packed {
		logic        start;
		logic [63:0] a_mag;
		logic [63:0] b_mag;
		logic [6:0]  nbits;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num_mag;
		logic [15:0] den;
		logic [6:0]  nbits;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

// File: design/ptd_mul.sv
// ptd_mul: bit-serial shift-and-add multiplier of unsigned magnitudes.
// Uses ptd_pkg request/response structs.
module ptd_mul import ptd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);
	logic [127:0] acc_q;
	logic [127:0] mcand_q;
	logic [63:0]  mplier_q;
	logic [6:0]   cnt_q;
	logic         busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= req.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mcand_q <= {64'd0, req.a_mag};
			mplier_q <= req.b_mag;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= {mcand_q[126:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[63:1]};
		end
	end

	assign rsp.done = busy_q && (cnt_q == 7'd1);
	assign rsp.prod = mplier_q[0] ? acc_q + mcand_q : acc_q;
endmodule

// File: design/ptd_div.sv
// ptd_div: restoring divider, one quotient bit per cycle, 16-bit divisor.
// Uses ptd_pkg request/response structs.
module ptd_div import ptd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [63:0] num_q;
	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;
	logic [16:0] sub;

	assign trial = {rem_q, num_q[63]};
	assign sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= req.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) busy_q <= 1'b0;
		end
	end

	// numerator register shifts out on top while quotient bits enter below;
	// the partial remainder stays below the divisor, so 16 bits hold it
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num_mag;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!sub[16]) begin
				rem_q <= sub[15:0];
				num_q <= {num_q[62:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				num_q <= {num_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = busy_q && (cnt_q == 7'd1);
	assign rsp.quo = {num_q[62:0], ~sub[16]};
endmodule

// File: design/ptd_ctrl.sv
// ptd_ctrl: sequencer for one sample; owns controller state and drives the
// shared serial multiplier and divider. Uses ptd_pkg.
module ptd_ctrl import ptd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic signed [31:0] meas,
	input  logic [15:0]       el,
	input  logic signed [31:0] kp,
	input  logic signed [31:0] ki,
	input  logic signed [31:0] kd,
	input  logic signed [31:0] target,
	input  logic [30:0]       dband,
	input  logic              mode,
	input  logic              tgt_wr,
	output logic              busy,
	output logic              res_valid,
	output logic signed [31:0] res_drive,
	output logic              res_sat,
	output logic              res_zero,
	output mul_req_t          mreq,
	input  mul_rsp_t          mrsp,
	output div_req_t          dreq,
	input  div_rsp_t          drsp
);
	state_t state_q, state_d;
	logic signed [47:0] isum_q;
	logic signed [32:0] last_q;
	logic               first_q;
	logic signed [32:0] e_q, prev_q;
	logic [15:0]        el_q;
	logic               neg_q;
	logic [63:0]        tmp_q;
	logic signed [63:0] p_q, i_q, d_q;
	logic signed [31:0] drv_q;
	logic               sat_q, zero_q;
	logic               act_q;

	logic signed [32:0] e_new;
	logic signed [33:0] sum2, dif;
	logic [32:0]        mag;
	logic signed [48:0] isum_new;
	logic signed [65:0] tot;
	logic signed [63:0] sq;
	logic [63:0]        qmag;
	logic [127:0]       pshift;

	assign e_new = 33'(target) - 33'(meas);
	assign mag = e_new[32] ? 33'(-e_new) : 33'(e_new);
	assign sum2 = 34'(e_q) + 34'(prev_q);
	assign dif = 34'(e_q) - 34'(prev_q);

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		abs64 = v[63] ? 64'(-v) : 64'(v);
	endfunction

	// clamp of (product >> 16) to 2^60, sign applied
	always_comb begin
		pshift = mrsp.prod >> 16;
		if (pshift > (128'd1 << TERM_SHIFT)) qmag = 64'd1 << TERM_SHIFT;
		else qmag = pshift[63:0];
		sq = neg_q ? 64'(-$signed(qmag)) : $signed(qmag);
	end

	// integral quotient signed
	always_comb begin
		logic signed [63:0] q;
		q = neg_q ? 64'(-$signed(drsp.quo)) : $signed(drsp.quo);
		isum_new = 49'(isum_q) + 49'(q);
	end

	assign tot = 66'(p_q) + 66'(i_q) + 66'(d_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (start) state_d = ST_ISUM_MUL;
			ST_ISUM_MUL: state_d = !act_q ? ST_OUT : ST_ISUM_DIV;
			ST_ISUM_DIV: if (drsp.done) state_d = ST_P_MUL;
			ST_P_MUL:    if (mrsp.done) state_d = ST_I_MUL;
			ST_I_MUL:    if (mrsp.done) state_d = (el_q == 16'd0) ? ST_SUM : ST_DNUM_MUL;
			ST_DNUM_MUL: state_d = ST_DNUM_DIV;
			ST_DNUM_DIV: if (drsp.done) state_d = ST_D_MUL;
			ST_D_MUL:    if (mrsp.done) state_d = ST_SUM;
			ST_SUM:      state_d = ST_OUT;
			ST_OUT:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// one operand multiply/divide requests per state entry
	logic [63:0] isum_abs;
	assign isum_abs = abs64(64'(isum_q));
	always_comb begin
		mreq = '0;
		dreq = '0;
		unique case (state_q)
			ST_ISUM_MUL: begin
				dreq.start = act_q;
				dreq.num_mag = 64'(el_q) * 64'(sum2[33] ? 34'(-sum2) : 34'(sum2));
				dreq.den = 16'd2000;
				dreq.nbits = 7'd64;
			end
			ST_ISUM_DIV: if (drsp.done) begin
				mreq.start = 1'b1;
				mreq.a_mag = abs64(64'(kp));
				mreq.b_mag = abs64(64'(e_q));
				mreq.nbits = 7'd34;
			end
			ST_P_MUL: if (mrsp.done) begin
				mreq.start = 1'b1;
				mreq.a_mag = abs64(64'(ki));
				mreq.b_mag = 64'(isum_abs);
				mreq.nbits = 7'd49;
			end
			ST_DNUM_MUL: begin
				dreq.start = 1'b1;
				dreq.num_mag = tmp_q;
				dreq.den = el_q;
				dreq.nbits = 7'd64;
			end
			ST_DNUM_DIV: if (drsp.done) begin
				mreq.start = 1'b1;
				mreq.a_mag = abs64(64'(kd));
				mreq.b_mag = drsp.quo;
				mreq.nbits = 7'd64;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign res_drive = drv_q;
	assign res_sat = sat_q;
	assign res_zero = zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			isum_q <= '0;
			last_q <= '0;
			first_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (tgt_wr) begin
				isum_q <= '0;
				first_q <= 1'b1;
			end else if (state_q == ST_IDLE && start) begin
				last_q <= e_new;
				first_q <= 1'b0;
			end else if (state_q == ST_ISUM_DIV && drsp.done) begin
				if (isum_new > 49'sh0_7FFF_FFFF_FFFF) isum_q <= 48'sh7FFF_FFFF_FFFF;
				else if (isum_new < -49'sh0_8000_0000_0000) isum_q <= 48'sh8000_0000_0000;
				else isum_q <= isum_new[47:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (start) begin
				e_q <= e_new;
				prev_q <= first_q ? e_new : last_q;
				el_q <= el;
				zero_q <= (el == 16'd0);
				act_q <= mode || (mag > 33'(dband));
				drv_q <= '0;
				sat_q <= 1'b0;
				d_q <= '0;
			end
			ST_ISUM_MUL: neg_q <= sum2[33];
			ST_ISUM_DIV: if (drsp.done) neg_q <= kp[31] ^ e_q[32];
			ST_P_MUL: if (mrsp.done) begin
				p_q <= sq;
				neg_q <= ki[31] ^ isum_q[47];
			end
			ST_I_MUL: if (mrsp.done) begin
				i_q <= sq;
				tmp_q <= 64'(dif[33] ? 34'(-dif) : 34'(dif)) * 64'd1000;
				neg_q <= dif[33];
			end
			ST_DNUM_MUL: ;
			ST_DNUM_DIV: if (drsp.done) neg_q <= kd[31] ^ neg_q;
			ST_D_MUL: if (mrsp.done) d_q <= sq;
			ST_SUM: begin
				if (tot > 66'sd2147483647) begin
					drv_q <= 32'sh7FFF_FFFF;
					sat_q <= 1'b1;
				end else if (tot < -66'sd2147483648) begin
					drv_q <= 32'sh8000_0000;
					sat_q <= 1'b1;
				end else drv_q <= tot[31:0];
			end
			default: ;
		endcase
	end
endmodule

// File: design/pid_trapezoid_deadband_core.sv
// pid_trapezoid_deadband_core: top level, config registers, output register.
// Depends on ptd_pkg, ptd_ctrl, ptd_mul, ptd_div.
//
// channel  direction  handshake            payload
// in       sink       in_valid/in_stall    measurement, elapsed_ms
// out      source     out_valid/out_stall  drive, saturated, zero_interval
// cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// out_valid rises once a taken item has passed through two 64-step serial divides
// and three serial multiplies (34, 49, 64 steps) on one shared bit-serial unit each.
// Zero elapsed_ms skips the derivative divide and multiply.
// Dead-band items skip all divides and multiplies. Reset clears config and state.
// A finished result waits in the output register; the next item is taken
// only once out_valid has fallen, which needs out not to be stalled.
module pid_trapezoid_deadband_core import ptd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [31:0] measurement,
	input  logic [15:0]       elapsed_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [31:0] drive,
	output logic              saturated,
	output logic              zero_interval,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]       cfg_data
);
	logic signed [31:0] kp_q, ki_q, kd_q, tgt_q;
	logic [30:0] db_q;
	logic mode_q;
	logic busy, res_valid, res_sat, res_zero, cfg_wr, tgt_wr, start;
	logic signed [31:0] res_drive;
	mul_req_t mreq;
	mul_rsp_t mrsp;
	div_req_t dreq;
	div_rsp_t drsp;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign tgt_wr = cfg_wr && (cfg_index == REG_TARGET);
	assign in_stall = busy || out_valid;
	assign start = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0; ki_q <= '0; kd_q <= '0; tgt_q <= '0; db_q <= '0; mode_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_PROP:   kp_q <= cfg_data;
				REG_INTEG:  ki_q <= cfg_data;
				REG_DERIV:  kd_q <= cfg_data;
				REG_TARGET: tgt_q <= cfg_data;
				REG_DBAND:  db_q <= cfg_data[30:0];
				REG_MODE:   mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (res_valid) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			drive <= res_drive;
			saturated <= res_sat;
			zero_interval <= res_zero;
		end
	end

	ptd_ctrl u_ctrl (
		.clk, .arst_n, .start, .meas(measurement), .el(elapsed_ms),
		.kp(kp_q), .ki(ki_q), .kd(kd_q), .target(tgt_q), .dband(db_q), .mode(mode_q),
		.tgt_wr, .busy, .res_valid, .res_drive, .res_sat, .res_zero,
		.mreq, .mrsp, .dreq, .drsp
	);
	ptd_mul u_mul (.clk, .arst_n, .req(mreq), .rsp(mrsp));
	ptd_div u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !start) else $error("item taken while busy");
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_valid) else $error("result overwrote pending output");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy) else $error("sequencer did not start");
endmodule

// File: bench/ptd_checker.sv
`timescale 1ns / 1ps
// ptd_checker: watches the cfg, in and out channels of the PID core, predicts each drive item
// and compares it field by field. Depends on ptd_pkg.
module ptd_checker import ptd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic signed [31:0]   measurement,
	input  logic [15:0]          elapsed_ms,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic signed [31:0]   drive,
	input  logic                 saturated,
	input  logic                 zero_interval,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   errors,
	output int                   pending
);

	typedef struct {
		logic signed [31:0] drive;
		logic               sat;
		logic               zint;
	} drive_item_t;

	typedef logic signed [127:0] wide_t;

	localparam wide_t TERM_MAX = wide_t'(1) <<< TERM_SHIFT;
	localparam wide_t ISUM_MAX = (wide_t'(1) <<< 47) - 1;
	localparam wide_t ISUM_MIN = -(wide_t'(1) <<< 47);
	localparam wide_t OUT_MAX  = 128'sh7FFFFFFF;
	localparam wide_t OUT_MIN  = -128'sh80000000;

	logic signed [31:0] kp, ki, kd, setpoint;
	logic [30:0]        band;
	logic               velocity;
	logic signed [47:0] isum;
	logic signed [32:0] prev_err;
	logic               first;
	drive_item_t        expected_drives[$];

	assign pending = expected_drives.size();

	// Q16.16 product, truncated toward zero, clamped to +-2^60
	function automatic wide_t qmul(wide_t a, wide_t b);
		wide_t p, m;
		p = a * b;
		m = (p < 0) ? -p : p;
		m = m >>> 16;
		if (m > TERM_MAX)
			m = TERM_MAX;
		return (p < 0) ? -m : m;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic predict_drive(input logic signed [31:0] meas, input logic [15:0] el);
		wide_t e, ep, mag, elw, s, p, i, d, sum;
		drive_item_t r;
		e = wide_t'(setpoint) - wide_t'(meas);
		mag = (e < 0) ? -e : e;
		elw = wide_t'({1'b0, el});
		if (first) begin
			prev_err = e[32:0];
			first = 1'b0;
		end
		ep = wide_t'(prev_err);
		r.drive = '0;
		r.sat = 1'b0;
		r.zint = (el == 0);
		if (velocity || mag > wide_t'({1'b0, band})) begin
			s = wide_t'(isum) + (elw * (e + ep)) / 2000;
			if (s > ISUM_MAX)
				s = ISUM_MAX;
			if (s < ISUM_MIN)
				s = ISUM_MIN;
			isum = s[47:0];
			p = qmul(wide_t'(kp), e);
			i = qmul(wide_t'(ki), s);
			d = (el != 0) ? qmul(wide_t'(kd), ((e - ep) * 1000) / elw) : wide_t'(0);
			sum = p + i + d;
			if (sum > OUT_MAX) begin
				sum = OUT_MAX;
				r.sat = 1'b1;
			end else if (sum < OUT_MIN) begin
				sum = OUT_MIN;
				r.sat = 1'b1;
			end
			r.drive = sum[31:0];
		end
		prev_err = e[32:0];
		expected_drives.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_item_t x;
		if (!arst_n) begin
			kp = '0; ki = '0; kd = '0; setpoint = '0; band = '0; velocity = 1'b0;
			isum = '0; prev_err = '0; first = 1'b1;
			expected_drives.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_PROP:  kp = cfg_data;
					REG_INTEG: ki = cfg_data;
					REG_DERIV: kd = cfg_data;
					REG_TARGET: begin
						setpoint = cfg_data;
						isum = '0;
						first = 1'b1;
					end
					REG_DBAND: band = cfg_data[30:0];
					REG_MODE:  velocity = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_drive(measurement, elapsed_ms);
			if (out_valid && !out_stall) begin
				if (expected_drives.size() == 0) begin
					$display("%0t: drive item with none expected", $realtime);
					errors++;
				end else begin
					x = expected_drives.pop_front();
					if (drive !== x.drive)
						report("drive", drive, x.drive);
					if (saturated !== x.sat)
						report("saturated", saturated, x.sat);
					if (zero_interval !== x.zint)
						report("zero_interval", zero_interval, x.zint);
				end
			end
		end
	end

	initial errors = 0;

endmodule

// File: bench/tb_pid_trapezoid_deadband_core.sv
`timescale 1ns / 1ps
// tb_pid_trapezoid_deadband_core: stimulus and verdict for the PID core.
// Depends on ptd_pkg, pid_trapezoid_deadband_core and ptd_checker.
module tb_pid_trapezoid_deadband_core import ptd_pkg::*;;

	logic                 clk, arst_n;
	logic                 in_valid, in_stall, out_valid, out_stall;
	logic signed [31:0]   measurement, drive;
	logic [15:0]          elapsed_ms;
	logic                 saturated, zero_interval;
	logic                 cfg_valid, cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	int                   errors, pending;
	int                   send_idle, recv_idle;

	pid_trapezoid_deadband_core dut (.*);

	ptd_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle);

	task automatic send(input logic [31:0] meas, input logic [15:0] el);
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1'b1;
		measurement <= meas;
		elapsed_ms <= el;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom;
			default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
		endcase
	endfunction

	task automatic random_setup();
		write_reg(REG_PROP, pick_gain());
		write_reg(REG_INTEG, pick_gain());
		write_reg(REG_DERIV, pick_gain());
		case ($urandom_range(0, 4))
			0: write_reg(REG_TARGET, 32'h7FFFFFFF);
			1: write_reg(REG_TARGET, 32'h80000000);
			2: write_reg(REG_TARGET, $urandom);
			default: write_reg(REG_TARGET, 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)));
		endcase
		case ($urandom_range(0, 4))
			0: write_reg(REG_DBAND, 32'h0);
			1: write_reg(REG_DBAND, 32'h7FFFFFFF);
			2: write_reg(REG_DBAND, $urandom);
			default: write_reg(REG_DBAND, $urandom_range(0, 1 << 18));
		endcase
		write_reg(REG_MODE, $urandom_range(0, 1));
	endtask

	function automatic logic [31:0] pick_meas(input logic [31:0] sp);
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2, 3: return $urandom;
			4: return sp;
			default: return sp + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic logic [15:0] pick_el();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 50));
		endcase
	endfunction

	initial begin
		logic [31:0] sp;
		arst_n = 1'b0;
		in_valid = 1'b0;
		measurement = '0;
		elapsed_ms = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle = 0;
		recv_idle = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: dead band, field extremes, zero interval, both modes, clipping
		write_reg(REG_PROP, 32'h0001_0000);
		write_reg(REG_INTEG, 32'h0000_0100);
		write_reg(REG_DERIV, 32'h0000_0080);
		write_reg(REG_TARGET, 32'h0005_0000);
		write_reg(REG_DBAND, 32'h0001_0000);
		write_reg(REG_MODE, 32'h0);
		send(32'h0005_0000, 16'd10);
		send(32'h0004_8000, 16'd0);
		send(32'h0003_0000, 16'd10);
		send(32'h7FFFFFFF, 16'hFFFF);
		send(32'h80000000, 16'd1);
		send(32'h0006_0001, 16'd0);
		wait_drained();
		write_reg(REG_MODE, 32'h1);
		send(32'h0005_0000, 16'd0);
		send(32'h0005_0000, 16'd20);
		send(32'h80000000, 16'hFFFF);
		send(32'h7FFFFFFF, 16'd1);
		wait_drained();
		write_reg(REG_PROP, 32'h7FFFFFFF);
		write_reg(REG_INTEG, 32'h80000000);
		write_reg(REG_DERIV, 32'h7FFFFFFF);
		write_reg(REG_TARGET, 32'h80000000);
		send(32'h7FFFFFFF, 16'hFFFF);
		send(32'h80000000, 16'd1);
		send(32'h7FFFFFFF, 16'd0);
		wait_drained();
		write_reg(REG_TARGET, 32'h7FFFFFFF);
		write_reg(REG_DBAND, 32'h7FFFFFFF);
		write_reg(REG_MODE, 32'h0);
		send(32'h80000000, 16'd3);
		send(32'h80000000, 16'd0);
		wait_drained();
		write_reg(REG_MODE, 32'h1);
		send(32'h80000000, 16'hFFFF);
		send(32'h0, 16'd7);
		wait_drained();

		// random phases: receiver busy, sender busy, no idling
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 32 : (ph == 1) ? 81 : 0;
			recv_idle = (ph == 0) ? 81 : (ph == 1) ? 32 : 0;
			for (int b = 0; b < 9; b++) begin
				random_setup();
				sp = chk.setpoint;
				for (int k = 0; k < 24; k++)
					send(pick_meas(sp), pick_el());
				wait_drained();
			end
		end

		wait_drained();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
